### rtl/uvs_pkg.sv
package uvs_pkg;

   // defaults for the top level parameters
   localparam int UVS_MAX_SPLITS    = 1024;
   localparam int UVS_CORDIC_STEPS  = 16;
   localparam int UVS_ATAN_LEN      = 24;

   // field widths
   localparam int CFG_W     = 11;
   localparam int COL_W     = 11;
   localparam int ROW_W     = 10;
   localparam int POS_W     = 16;
   localparam int IDX_W     = 21;
   localparam int CSR_IDX_W = 2;

   // long division produces this many quotient bits, one per stage
   localparam int DIV_QUO_W = 33;

   // cordic datapath width, Q2.30 plus guard bits
   localparam int CORDIC_W = 34;
   localparam logic [31:0] CORDIC_GAIN_INV = 32'h26DD3B6A;

   localparam logic [CFG_W-1:0] COLUMNS_RESET = CFG_W'(16);
   localparam logic [CFG_W-1:0] ROWS_RESET    = CFG_W'(16);

   // register map
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_COLUMNS = CSR_IDX_W'(0),
      CSR_ROWS    = CSR_IDX_W'(1)
   } csr_index_type;

   // request commands
   typedef enum logic {
      CMD_VERTEX = 1'b0,
      CMD_CELL   = 1'b1
   } cmd_type;

   // arctangent of 2^-i as a fraction of a full turn
   function automatic logic [31:0] turn_atan(input int i);
      logic [31:0] a;
      case (i)
         0:       a = 32'h20000000;
         1:       a = 32'h12E4051E;
         2:       a = 32'h09FB385B;
         3:       a = 32'h051111D4;
         4:       a = 32'h028B0D43;
         5:       a = 32'h0145D7E1;
         6:       a = 32'h00A2F61E;
         7:       a = 32'h00517C55;
         8:       a = 32'h0028BE53;
         9:       a = 32'h00145F2F;
         10:      a = 32'h000A2F98;
         11:      a = 32'h000517CC;
         12:      a = 32'h00028BE6;
         13:      a = 32'h000145F3;
         14:      a = 32'h0000A2FA;
         15:      a = 32'h0000517D;
         16:      a = 32'h000028BE;
         17:      a = 32'h0000145F;
         18:      a = 32'h00000A30;
         19:      a = 32'h00000518;
         20:      a = 32'h0000028C;
         21:      a = 32'h00000146;
         22:      a = 32'h000000A3;
         23:      a = 32'h00000051;
         default: a = 32'h0;
      endcase
      return a;
   endfunction

endpackage

### rtl/uvs_divider.sv
module uvs_divider #(
   parameter int DEN_W = 11,
   parameter int QUO_W = 33
) (
   input  logic                   clock,
   input  logic                   adv,
   input  logic [QUO_W+DEN_W-1:0] num,
   input  logic [DEN_W-1:0]       den,
   output logic [QUO_W-1:0]       quo
);

   logic [DEN_W-1:0] rem_ff [0:QUO_W-1];
   logic [QUO_W-1:0] low_ff [0:QUO_W-1];
   logic [DEN_W-1:0] den_ff [0:QUO_W-1];
   logic [QUO_W-1:0] quo_ff [0:QUO_W];

   // load: upper part is the starting remainder, lower part feeds one bit a stage
   always_ff @(posedge clock) begin
      if (adv) begin
         rem_ff[0] <= num[QUO_W+DEN_W-1:QUO_W];
         low_ff[0] <= num[QUO_W-1:0];
         den_ff[0] <= den;
         quo_ff[0] <= '0;
      end
   end

   // one restoring step per stage
   for (genvar i = 0; i < QUO_W; i++) begin : g_step
      logic [DEN_W:0] trial;
      logic [DEN_W:0] diff;
      logic           ge;

      always_comb begin
         trial = {rem_ff[i], low_ff[i][QUO_W-1]};
         diff  = trial - {1'b0, den_ff[i]};
         ge    = (trial >= {1'b0, den_ff[i]});
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            quo_ff[i+1] <= {quo_ff[i][QUO_W-2:0], ge};
         end
      end

      if (i < QUO_W - 1) begin : g_carry
         always_ff @(posedge clock) begin
            if (adv) begin
               rem_ff[i+1] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
               low_ff[i+1] <= {low_ff[i][QUO_W-2:0], 1'b0};
               den_ff[i+1] <= den_ff[i];
            end
         end
      end
   end

   assign quo = quo_ff[QUO_W];

endmodule

### rtl/uvs_cordic.sv
module uvs_cordic #(
   parameter int STEPS = uvs_pkg::UVS_CORDIC_STEPS
) (
   input  logic               clock,
   input  logic               adv,
   input  logic [31:0]        angle,
   output logic signed [31:0] sin_out,
   output logic signed [31:0] cos_out
);
   import uvs_pkg::*;

   localparam int W = CORDIC_W;

   logic signed [W-1:0] x_ff [0:STEPS];
   logic signed [W-1:0] y_ff [0:STEPS];
   logic signed [W-1:0] z_ff [0:STEPS];
   logic                flip_ff [0:STEPS];
   logic                flip_in;
   logic [31:0]         rot_angle;
   logic signed [31:0]  sin_ff;
   logic signed [31:0]  cos_ff;

   // second and third quarter turn: rotate by a half turn, negate at the end
   always_comb begin
      flip_in   = angle[31] ^ angle[30];
      rot_angle = flip_in ? {~angle[31], angle[30:0]} : angle;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         x_ff[0]    <= {{(W-32){1'b0}}, CORDIC_GAIN_INV};
         y_ff[0]    <= '0;
         z_ff[0]    <= {{(W-32){rot_angle[31]}}, rot_angle};
         flip_ff[0] <= flip_in;
      end
   end

   // one micro-rotation per stage
   for (genvar i = 0; i < STEPS; i++) begin : g_step
      logic signed [W-1:0] xs;
      logic signed [W-1:0] ys;
      logic signed [W-1:0] atan_ext;

      always_comb begin
         xs       = x_ff[i] >>> i;
         ys       = y_ff[i] >>> i;
         atan_ext = W'(turn_atan(i));
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            flip_ff[i+1] <= flip_ff[i];
            if (!z_ff[i][W-1]) begin
               x_ff[i+1] <= x_ff[i] - ys;
               y_ff[i+1] <= y_ff[i] + xs;
               z_ff[i+1] <= z_ff[i] - atan_ext;
            end else begin
               x_ff[i+1] <= x_ff[i] + ys;
               y_ff[i+1] <= y_ff[i] - xs;
               z_ff[i+1] <= z_ff[i] + atan_ext;
            end
         end
      end
   end

   // undo the half turn
   always_ff @(posedge clock) begin
      if (adv) begin
         cos_ff <= flip_ff[STEPS] ? 32'(-x_ff[STEPS]) : 32'(x_ff[STEPS]);
         sin_ff <= flip_ff[STEPS] ? 32'(-y_ff[STEPS]) : 32'(y_ff[STEPS]);
      end
   end

   assign sin_out = sin_ff;
   assign cos_out = cos_ff;

endmodule

### rtl/uvs_delay.sv
module uvs_delay #(
   parameter int W     = 8,
   parameter int DEPTH = 1
) (
   input  logic         clock,
   input  logic         adv,
   input  logic [W-1:0] din,
   output logic [W-1:0] dout
);

   logic [W-1:0] data_ff [0:DEPTH-1];

   // side data shifts along with the arithmetic stages
   always_ff @(posedge clock) begin
      if (adv) begin
         data_ff[0] <= din;
         for (int i = 1; i < DEPTH; i++) begin
            data_ff[i] <= data_ff[i-1];
         end
      end
   end

   assign dout = data_ff[DEPTH-1];

endmodule

### rtl/uv_sphere_vertex_index_generator_core.sv
// channel  dir  handshake            beat contents
// req      in   req_valid/req_stall  cmd, col, row
// rsp      out  rsp_valid/rsp_stall  is_triangle, pos_x/y/z, tex_u/v, corner_a/b/c,
//                                    bad_request, last
// csr      in   csr_write            csr_index, csr_wdata
//
// one request enters per cycle while req_stall is low; a cell with two triangles stalls req
// until its second triangle enters the output register; on its way to the first rsp beat a
// request passes the 33-stage long division followed by the CORDIC_STEPS-stage rotation pipeline
// the whole pipeline advances together; a stalled rsp beat freezes every stage
// reset is synchronous, clears the valid bits and sets both configuration registers to 16
module uv_sphere_vertex_index_generator_core #(
   parameter int MAX_SPLITS   = uvs_pkg::UVS_MAX_SPLITS,
   parameter int CORDIC_STEPS = uvs_pkg::UVS_CORDIC_STEPS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_cmd,
   input  logic [uvs_pkg::COL_W-1:0]     req_col,
   input  logic [uvs_pkg::ROW_W-1:0]     req_row,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_is_triangle,
   output logic signed [uvs_pkg::POS_W-1:0] rsp_pos_x,
   output logic signed [uvs_pkg::POS_W-1:0] rsp_pos_y,
   output logic signed [uvs_pkg::POS_W-1:0] rsp_pos_z,
   output logic signed [uvs_pkg::POS_W-1:0] rsp_tex_u,
   output logic [uvs_pkg::POS_W-1:0]     rsp_tex_v,
   output logic [uvs_pkg::IDX_W-1:0]     rsp_corner_a,
   output logic [uvs_pkg::IDX_W-1:0]     rsp_corner_b,
   output logic [uvs_pkg::IDX_W-1:0]     rsp_corner_c,
   output logic                          rsp_bad_request,
   output logic                          rsp_last,
   input  logic                          csr_write,
   input  logic [uvs_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [uvs_pkg::CFG_W-1:0]     csr_wdata
);
   import uvs_pkg::*;

   localparam int Q        = DIV_QUO_W;
   localparam int DIV_LAT  = Q + 1;
   localparam int CL       = CORDIC_STEPS + 2;
   localparam int MUL_STG  = DIV_LAT + CL + 1;
   localparam int FIN_STG  = MUL_STG + 1;
   localparam int WID_W    = CFG_W + 1;

   typedef struct packed {
      logic             cmd;
      logic             bad;
      logic             neg_u;
      logic             t1;
      logic             t2;
      logic [IDX_W-1:0] base;
      logic [WID_W-1:0] w;
   } sb1_type;

   typedef struct packed {
      sb1_type          head;
      logic [POS_W-1:0] uq;
      logic [POS_W-1:0] vq;
   } sb2_type;

   typedef struct packed {
      logic             is_triangle;
      logic [POS_W-1:0] pos_x;
      logic [POS_W-1:0] pos_y;
      logic [POS_W-1:0] pos_z;
      logic [POS_W-1:0] tex_u;
      logic [POS_W-1:0] tex_v;
      logic [IDX_W-1:0] corner_a;
      logic [IDX_W-1:0] corner_b;
      logic [IDX_W-1:0] corner_c;
      logic             bad_request;
      logic             last;
   } rsp_type;

   // Q4.60 to Q1.15, round half up, saturate
   function automatic logic [POS_W-1:0] rnd60(input logic signed [64:0] v);
      logic signed [64:0] s;
      logic [POS_W-1:0]   r;
      s = (v + 65'sh100000000000) >>> 45;
      if (s > 65'sd32767) begin
         r = 16'h7FFF;
      end else if (s < -65'sd32768) begin
         r = 16'h8000;
      end else begin
         r = s[POS_W-1:0];
      end
      return r;
   endfunction

   // Q2.30 to Q1.15, round half up, saturate
   function automatic logic [POS_W-1:0] rnd30(input logic signed [33:0] v);
      logic signed [33:0] s;
      logic [POS_W-1:0]   r;
      s = (v + 34'sh4000) >>> 15;
      if (s > 34'sd32767) begin
         r = 16'h7FFF;
      end else if (s < -34'sd32768) begin
         r = 16'h8000;
      end else begin
         r = s[POS_W-1:0];
      end
      return r;
   endfunction

   logic [CFG_W-1:0]   columns_ff;
   logic [CFG_W-1:0]   rows_ff;
   logic [CFG_W-1:0]   nc_eff;
   logic [CFG_W-1:0]   nr_eff;
   logic [FIN_STG:0]   vld_ff;
   logic               adv;
   logic               out_free;

   logic               cmd_ff;
   logic [COL_W-1:0]   col_ff;
   logic [ROW_W-1:0]   row_ff;
   logic [CFG_W-1:0]   nc_ff;
   logic [CFG_W-1:0]   den_ff;

   logic               at_first;
   logic               at_last;
   logic [COL_W+1:0]   e_u;
   logic [Q+CFG_W-1:0] num_lon;
   logic [Q+CFG_W-1:0] num_lat;
   logic [Q+CFG_W-1:0] num_v;
   logic [Q+WID_W-1:0] num_u;
   logic [WID_W-1:0]   den_u;
   logic [22:0]        base_full;
   sb1_type            sb1_in;
   sb1_type            sb1_out;
   logic [Q-1:0]       quo_lon;
   logic [Q-1:0]       quo_lat;
   logic [Q-1:0]       quo_u;
   logic [Q-1:0]       quo_v;
   sb2_type            sb2_in;
   sb2_type            sb2_out;
   logic signed [31:0] sin_lon;
   logic signed [31:0] cos_lon;
   logic signed [31:0] sin_lat;
   logic signed [31:0] cos_lat;

   sb2_type            mul_sb_ff;
   logic signed [63:0] prod_x_ff;
   logic signed [63:0] prod_z_ff;
   logic signed [31:0] cb_ff;
   logic signed [63:0] prod_x_in;
   logic signed [63:0] prod_z_in;

   rsp_type            res1_in;
   rsp_type            res2_in;
   logic [1:0]         cnt_in;
   rsp_type            res1_ff;
   rsp_type            res2_ff;
   logic [1:0]         cnt_ff;

   rsp_type            rsp_ff;
   rsp_type            hold_ff;
   logic               rsp_valid_ff;
   logic               pend_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         columns_ff <= COLUMNS_RESET;
         rows_ff    <= ROWS_RESET;
      end else if (csr_write) begin
         unique case (csr_index_type'(csr_index))
            CSR_COLUMNS: columns_ff <= csr_wdata;
            CSR_ROWS:    rows_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   // clamp the grid size
   always_comb begin
      if (columns_ff == '0) begin
         nc_eff = CFG_W'(1);
      end else if (32'(columns_ff) > MAX_SPLITS) begin
         nc_eff = CFG_W'(MAX_SPLITS);
      end else begin
         nc_eff = columns_ff;
      end
      if (rows_ff < CFG_W'(2)) begin
         nr_eff = CFG_W'(2);
      end else if (32'(rows_ff) > MAX_SPLITS) begin
         nr_eff = CFG_W'(MAX_SPLITS);
      end else begin
         nr_eff = rows_ff;
      end
   end

   // global advance: the output slot can take a beat and no second triangle waits
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign adv       = out_free && !pend_ff;
   assign req_stall = !adv;

   // valid bits travel with the stages
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[FIN_STG-1:0], req_valid};
      end
   end

   // input stage
   always_ff @(posedge clock) begin
      if (adv) begin
         cmd_ff <= req_cmd;
         col_ff <= req_col;
         row_ff <= req_row;
         nc_ff  <= nc_eff;
         den_ff <= nr_eff - CFG_W'(1);
      end
   end

   // range checks, numerators and cell base index
   always_comb begin
      at_first  = (row_ff == '0);
      at_last   = ({1'b0, row_ff} == den_ff);
      sb1_in.cmd   = cmd_ff;
      sb1_in.bad   = (cmd_ff == CMD_CELL)
                     ? ((col_ff >= nc_ff) || ({1'b0, row_ff} >= den_ff))
                     : ((col_ff > nc_ff) || ({1'b0, row_ff} > den_ff));
      sb1_in.neg_u = at_first && (col_ff == '0);
      sb1_in.t1    = !at_first;
      sb1_in.t2    = ({1'b0, row_ff} != den_ff - CFG_W'(1));
      sb1_in.w     = {1'b0, nc_ff} + WID_W'(1);
      base_full    = 23'(row_ff) * 23'(sb1_in.w) + 23'(col_ff);
      sb1_in.base  = base_full[IDX_W-1:0];

      num_lon = ((Q+CFG_W)'(col_ff) << 32) + (Q+CFG_W)'(nc_ff >> 1);
      num_lat = ((Q+CFG_W)'(row_ff) << 31) + (Q+CFG_W)'(den_ff >> 1);
      num_v   = ((Q+CFG_W)'(row_ff) << 15) + (Q+CFG_W)'(den_ff >> 1);

      e_u = {1'b0, col_ff, 1'b0} + (COL_W+2)'(at_last && !at_first)
            - (COL_W+2)'(at_first);
      den_u = {nc_ff, 1'b0};
      if (sb1_in.neg_u) begin
         num_u = (Q+WID_W)'(16384) + (Q+WID_W)'(nc_ff) - (Q+WID_W)'(1);
      end else begin
         num_u = ((Q+WID_W)'(e_u) << 14) + (Q+WID_W)'(nc_ff);
      end
   end

   uvs_divider #(.DEN_W(CFG_W), .QUO_W(Q)) u_div_lon (
      .clock(clock), .adv(adv), .num(num_lon), .den(nc_ff), .quo(quo_lon)
   );

   uvs_divider #(.DEN_W(CFG_W), .QUO_W(Q)) u_div_lat (
      .clock(clock), .adv(adv), .num(num_lat), .den(den_ff), .quo(quo_lat)
   );

   uvs_divider #(.DEN_W(WID_W), .QUO_W(Q)) u_div_u (
      .clock(clock), .adv(adv), .num(num_u), .den(den_u), .quo(quo_u)
   );

   uvs_divider #(.DEN_W(CFG_W), .QUO_W(Q)) u_div_v (
      .clock(clock), .adv(adv), .num(num_v), .den(den_ff), .quo(quo_v)
   );

   uvs_delay #(.W($bits(sb1_type)), .DEPTH(DIV_LAT)) u_sb1 (
      .clock(clock), .adv(adv), .din(sb1_in), .dout(sb1_out)
   );

   // angles feed the rotation pipelines
   uvs_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_lon (
      .clock(clock), .adv(adv), .angle(quo_lon[31:0]),
      .sin_out(sin_lon), .cos_out(cos_lon)
   );

   uvs_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_lat (
      .clock(clock), .adv(adv), .angle(quo_lat[31:0]),
      .sin_out(sin_lat), .cos_out(cos_lat)
   );

   always_comb begin
      sb2_in.head = sb1_out;
      sb2_in.uq   = quo_u[POS_W-1:0];
      sb2_in.vq   = quo_v[POS_W-1:0];
   end

   uvs_delay #(.W($bits(sb2_type)), .DEPTH(CL)) u_sb2 (
      .clock(clock), .adv(adv), .din(sb2_in), .dout(sb2_out)
   );

   // product stage
   assign prod_x_in = cos_lon * sin_lat;
   assign prod_z_in = sin_lon * sin_lat;

   always_ff @(posedge clock) begin
      if (adv) begin
         mul_sb_ff <= sb2_out;
         prod_x_ff <= prod_x_in;
         prod_z_ff <= prod_z_in;
         cb_ff     <= cos_lat;
      end
   end

   // format the result beats
   always_comb begin
      rsp_type up_tri;
      rsp_type dn_tri;
      sb1_type h;
      h       = mul_sb_ff.head;
      res1_in = '0;
      res2_in = '0;
      cnt_in  = 2'd0;
      up_tri  = '0;
      dn_tri  = '0;
      up_tri.is_triangle = 1'b1;
      up_tri.corner_a    = h.base;
      up_tri.corner_b    = h.base + IDX_W'(1);
      up_tri.corner_c    = h.base + IDX_W'(h.w);
      dn_tri.is_triangle = 1'b1;
      dn_tri.corner_a    = h.base + IDX_W'(h.w);
      dn_tri.corner_b    = h.base + IDX_W'(1);
      dn_tri.corner_c    = h.base + IDX_W'(h.w) + IDX_W'(1);
      dn_tri.last        = 1'b1;
      if (h.bad) begin
         res1_in.is_triangle = h.cmd;
         res1_in.bad_request = 1'b1;
         res1_in.last        = 1'b1;
         cnt_in              = 2'd1;
      end else if (h.cmd == CMD_VERTEX) begin
         res1_in.pos_x = rnd60({prod_x_ff[63], prod_x_ff});
         res1_in.pos_y = rnd30(-{{2{cb_ff[31]}}, cb_ff});
         res1_in.pos_z = rnd60(-{prod_z_ff[63], prod_z_ff});
         res1_in.tex_u = h.neg_u ? POS_W'(POS_W'(0) - mul_sb_ff.uq) : mul_sb_ff.uq;
         res1_in.tex_v = mul_sb_ff.vq;
         res1_in.last  = 1'b1;
         cnt_in        = 2'd1;
      end else if (h.t1 && h.t2) begin
         res1_in = up_tri;
         res2_in = dn_tri;
         cnt_in  = 2'd2;
      end else if (h.t1) begin
         res1_in      = up_tri;
         res1_in.last = 1'b1;
         cnt_in       = 2'd1;
      end else if (h.t2) begin
         res1_in = dn_tri;
         cnt_in  = 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         res1_ff <= res1_in;
         res2_ff <= res2_in;
         cnt_ff  <= cnt_in;
      end
   end

   // output register with a hold slot for the second triangle
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
      end else if (out_free) begin
         if (pend_ff) begin
            rsp_valid_ff <= 1'b1;
            pend_ff      <= 1'b0;
         end else if (vld_ff[FIN_STG] && (cnt_ff != 2'd0)) begin
            rsp_valid_ff <= 1'b1;
            pend_ff      <= (cnt_ff == 2'd2);
         end else begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         if (pend_ff) begin
            rsp_ff <= hold_ff;
         end else begin
            rsp_ff  <= res1_ff;
            hold_ff <= res2_ff;
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_is_triangle = rsp_ff.is_triangle;
   assign rsp_pos_x       = rsp_ff.pos_x;
   assign rsp_pos_y       = rsp_ff.pos_y;
   assign rsp_pos_z       = rsp_ff.pos_z;
   assign rsp_tex_u       = rsp_ff.tex_u;
   assign rsp_tex_v       = rsp_ff.tex_v;
   assign rsp_corner_a    = rsp_ff.corner_a;
   assign rsp_corner_b    = rsp_ff.corner_b;
   assign rsp_corner_c    = rsp_ff.corner_c;
   assign rsp_bad_request = rsp_ff.bad_request;
   assign rsp_last        = rsp_ff.last;

endmodule

### rtl/uvs_checker.sv
module uvs_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input logic                          req_cmd,
   input logic [uvs_pkg::COL_W-1:0]     req_col,
   input logic [uvs_pkg::ROW_W-1:0]     req_row,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic                          rsp_is_triangle,
   input logic [uvs_pkg::POS_W-1:0]     rsp_pos_x,
   input logic [uvs_pkg::POS_W-1:0]     rsp_pos_y,
   input logic [uvs_pkg::POS_W-1:0]     rsp_pos_z,
   input logic [uvs_pkg::POS_W-1:0]     rsp_tex_u,
   input logic [uvs_pkg::POS_W-1:0]     rsp_tex_v,
   input logic [uvs_pkg::IDX_W-1:0]     rsp_corner_a,
   input logic [uvs_pkg::IDX_W-1:0]     rsp_corner_b,
   input logic [uvs_pkg::IDX_W-1:0]     rsp_corner_c,
   input logic                          rsp_bad_request,
   input logic                          rsp_last,
   input logic                          csr_write,
   input logic [uvs_pkg::CSR_IDX_W-1:0] csr_index,
   input logic [uvs_pkg::CFG_W-1:0]     csr_wdata
);

   // no beat right after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp beat right after reset");

   // a stalled beat stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("rsp beat dropped under stall");

   // a bad request beat closes its request and carries no corners, no pos_x and no tex_v
   a_bad_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bad_request |-> rsp_last && rsp_corner_a == '0 &&
      rsp_corner_b == '0 && rsp_corner_c == '0 && rsp_pos_x == '0 && rsp_tex_v == '0)
      else $error("bad request beat with payload");

   // a vertex beat is single and has no corner_a or corner_c
   a_vertex_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_is_triangle |-> rsp_last && rsp_corner_a == '0 &&
      rsp_corner_c == '0)
      else $error("vertex beat not closing its request");

   // first of two triangles is followed at once by the closing triangle
   a_pair: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last && !rsp_stall |=> rsp_valid && rsp_is_triangle && rsp_last &&
      !rsp_bad_request)
      else $error("second triangle missing");

endmodule

bind uv_sphere_vertex_index_generator_core uvs_checker u_uvs_checker (.*);

### dv/uv_sphere_vertex_index_generator_core_tb.sv
`timescale 1ns / 1ps

module uv_sphere_vertex_index_generator_core_tb;
   import uvs_pkg::*;

   localparam int FLUSH_CYCLES = 120;
   localparam int CYCLE_LIMIT = 400000;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = CSR_IDX_W'(3);

   typedef struct {
      cmd_type cmd;
      logic [COL_W-1:0] col;
      logic [ROW_W-1:0] row;
   } request_type;

   typedef struct {
      logic is_tri;
      logic signed [POS_W-1:0] px, py, pz, tu;
      logic [POS_W-1:0] tv;
      logic [IDX_W-1:0] ca, cb, cc;
      logic bad;
      logic last;
   } geom_beat_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_cmd = 1'b0;
   logic [COL_W-1:0] req_col = '0;
   logic [ROW_W-1:0] req_row = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic rsp_is_triangle;
   logic signed [POS_W-1:0] rsp_pos_x, rsp_pos_y, rsp_pos_z, rsp_tex_u;
   logic [POS_W-1:0] rsp_tex_v;
   logic [IDX_W-1:0] rsp_corner_a, rsp_corner_b, rsp_corner_c;
   logic rsp_bad_request, rsp_last;
   logic csr_write = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CFG_W-1:0] csr_wdata = '0;

   request_type pending_reqs[$];
   geom_beat_type expected_beats[$];
   int errors = 0;
   int cycles = 0;
   int vertex_beats = 0, triangle_beats = 0, bad_beats = 0, settings_run = 0;
   bit idle_enable = 1'b1;
   logic [CFG_W-1:0] columns_reg = COLUMNS_RESET;
   logic [CFG_W-1:0] rows_reg = ROWS_RESET;

   uv_sphere_vertex_index_generator_core DUT (.*);

   always #10 clock = ~clock;

   // angle of atan(2^-i) in fractions of a turn
   function automatic longint atan_turn(int i);
      longint atan_tab[16] = '{
         64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
         64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
         64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
         64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D};
      return atan_tab[i];
   endfunction

   function automatic longint eff_columns();
      if (columns_reg < 1) return 1;
      if (columns_reg > UVS_MAX_SPLITS) return UVS_MAX_SPLITS;
      return columns_reg;
   endfunction

   function automatic longint eff_rows();
      if (rows_reg < 2) return 2;
      if (rows_reg > UVS_MAX_SPLITS) return UVS_MAX_SPLITS;
      return rows_reg;
   endfunction

   function automatic longint sat16(longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
   endfunction

   // rotation cordic over a turn-fraction angle, half turn folded
   function automatic void rotate_angle(bit [31:0] angle, output longint s, output longint c);
      bit flip;
      bit [31:0] a;
      int za;
      longint x, y, z, xs, ys;
      flip = (angle[31:30] == 2'd1) || (angle[31:30] == 2'd2);
      a = flip ? angle - 32'h80000000 : angle;
      za = a;
      z = za;
      x = CORDIC_GAIN_INV;
      y = 0;
      for (int i = 0; i < UVS_CORDIC_STEPS; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (z >= 0) begin
            x = x - ys;
            y = y + xs;
            z = z - atan_turn(i);
         end else begin
            x = x + ys;
            y = y - xs;
            z = z + atan_turn(i);
         end
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
   endfunction

   function automatic geom_beat_type blank_beat();
      geom_beat_type b;
      b = '{default: '0};
      return b;
   endfunction

   // work out the beats one request produces
   function automatic void predict_geometry(request_type rq);
      longint nc, nr, den, c, r, w, sl, cl, sb, cb, n, d2, u;
      bit [31:0] lon, lat;
      int dd;
      geom_beat_type b;
      geom_beat_type tris[$];
      nc = eff_columns();
      nr = eff_rows();
      den = nr - 1;
      c = rq.col;
      r = rq.row;
      b = blank_beat();
      if (rq.cmd == CMD_VERTEX) begin
         b.last = 1'b1;
         if (c > nc || r >= nr) begin
            b.bad = 1'b1;
         end else begin
            lon = 32'(((c << 32) + nc / 2) / nc);
            lat = 32'(((r << 31) + den / 2) / den);
            rotate_angle(lon, sl, cl);
            rotate_angle(lat, sb, cb);
            dd = (r == 0) ? -1 : ((r == nr - 1) ? 1 : 0);
            d2 = 2 * nc;
            n = (2 * c + dd) * 16384 + nc;
            u = (n >= 0) ? n / d2 : -((-n + d2 - 1) / d2);
            b.px = 16'(sat16((cl * sb + (64'sd1 <<< 44)) >>> 45));
            b.py = 16'(sat16((-cb + (64'sd1 <<< 14)) >>> 15));
            b.pz = 16'(sat16((-(sl * sb) + (64'sd1 <<< 44)) >>> 45));
            b.tu = 16'(sat16(u));
            b.tv = 16'(((r << 15) + den / 2) / den);
         end
         expected_beats.push_back(b);
      end else begin
         w = nc + 1;
         b.is_tri = 1'b1;
         if (c >= nc || r >= nr - 1) begin
            b.bad = 1'b1;
            b.last = 1'b1;
            expected_beats.push_back(b);
         end else begin
            // upper triangle dropped at the top pole row, lower one at the bottom
            if (r != 0) begin
               b.ca = 21'(r * w + c);
               b.cb = 21'(r * w + c + 1);
               b.cc = 21'((r + 1) * w + c);
               tris.push_back(b);
            end
            if (r != nr - 2) begin
               b.ca = 21'((r + 1) * w + c);
               b.cb = 21'(r * w + c + 1);
               b.cc = 21'((r + 1) * w + c + 1);
               tris.push_back(b);
            end
            if (tris.size() > 0) tris[tris.size() - 1].last = 1'b1;
            foreach (tris[i]) expected_beats.push_back(tris[i]);
         end
      end
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      errors++;
      $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
   endtask

   task automatic add_req(cmd_type cmd, longint col, longint row);
      request_type rq;
      rq.cmd = cmd;
      rq.col = COL_W'(col);
      rq.row = ROW_W'(row);
      pending_reqs.push_back(rq);
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            predict_geometry('{cmd_type'(req_cmd), req_col, req_row});
         end
         if (!req_valid || !req_stall) begin
            if (pending_reqs.size() != 0 &&
                !(idle_enable && $urandom_range(99) < 7)) begin
               request_type rq;
               rq = pending_reqs.pop_front();
               req_valid <= 1'b1;
               req_cmd <= rq.cmd;
               req_col <= rq.col;
               req_row <= rq.row;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      geom_beat_type e;
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout waiting for results");
         $display("simulation failed");
         $finish;
      end
      rsp_stall <= reset ? 1'b0 : (idle_enable && $urandom_range(99) < 7);
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_beats.size() == 0) begin
            report_mismatch("unexpected beat", 1, 0);
         end else begin
            e = expected_beats.pop_front();
            if (rsp_is_triangle !== e.is_tri) report_mismatch("is_triangle", rsp_is_triangle, e.is_tri);
            if (rsp_pos_x !== e.px) report_mismatch("pos_x", rsp_pos_x, e.px);
            if (rsp_pos_y !== e.py) report_mismatch("pos_y", rsp_pos_y, e.py);
            if (rsp_pos_z !== e.pz) report_mismatch("pos_z", rsp_pos_z, e.pz);
            if (rsp_tex_u !== e.tu) report_mismatch("tex_u", rsp_tex_u, e.tu);
            if (rsp_tex_v !== e.tv) report_mismatch("tex_v", rsp_tex_v, e.tv);
            if (rsp_corner_a !== e.ca) report_mismatch("corner_a", rsp_corner_a, e.ca);
            if (rsp_corner_b !== e.cb) report_mismatch("corner_b", rsp_corner_b, e.cb);
            if (rsp_corner_c !== e.cc) report_mismatch("corner_c", rsp_corner_c, e.cc);
            if (rsp_bad_request !== e.bad) report_mismatch("bad_request", rsp_bad_request, e.bad);
            if (rsp_last !== e.last) report_mismatch("last", rsp_last, e.last);
            if (e.bad) bad_beats++;
            else if (e.is_tri) triangle_beats++;
            else vertex_beats++;
         end
      end
   end

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_write <= 1'b0;
      if (idx == CSR_COLUMNS) columns_reg = value;
      else if (idx == CSR_ROWS) rows_reg = value;
   endtask

   // wait for every beat, then let the pipeline empty out
   task automatic drain();
      while (pending_reqs.size() != 0 || req_valid || expected_beats.size() != 0)
         @(posedge clock);
      repeat (FLUSH_CYCLES) @(posedge clock);
   endtask

   // corners, edges, centre and out-of-range requests of the current grid
   task automatic add_directed();
      longint nc, nr;
      nc = eff_columns();
      nr = eff_rows();
      add_req(CMD_VERTEX, 0, 0);
      add_req(CMD_VERTEX, nc, 0);
      add_req(CMD_VERTEX, 0, nr - 1);
      add_req(CMD_VERTEX, nc, nr - 1);
      add_req(CMD_VERTEX, nc / 2, (nr - 1) / 2);
      add_req(CMD_VERTEX, nc + 1, 0);
      add_req(CMD_VERTEX, 0, nr);
      add_req(CMD_VERTEX, 2047, 1023);
      add_req(CMD_CELL, 0, 0);
      add_req(CMD_CELL, nc - 1, nr - 2);
      add_req(CMD_CELL, nc - 1, 0);
      add_req(CMD_CELL, 0, nr - 2);
      add_req(CMD_CELL, nc / 2, (nr - 2) / 2);
      add_req(CMD_CELL, nc, 0);
      add_req(CMD_CELL, 0, nr - 1);
      add_req(CMD_CELL, 2047, 1023);
   endtask

   // mostly in-grid requests, some anywhere in the field range
   task automatic add_random(int count);
      longint nc, nr;
      cmd_type cmd;
      nc = eff_columns();
      nr = eff_rows();
      repeat (count) begin
         cmd = cmd_type'($urandom_range(1));
         if ($urandom_range(99) < 12)
            add_req(cmd, $urandom_range(2047), $urandom_range(1023));
         else if (cmd == CMD_VERTEX)
            add_req(cmd, $urandom_range(nc), $urandom_range(nr - 1));
         else
            add_req(cmd, $urandom_range(nc - 1), $urandom_range(nr - 2));
      end
   endtask

   task automatic run_setting(logic [CFG_W-1:0] cols, logic [CFG_W-1:0] rws, int count);
      write_csr(CSR_COLUMNS, cols);
      write_csr(CSR_ROWS, rws);
      settings_run++;
      add_directed();
      add_random(count);
      drain();
   endtask

   // stimulus sequence
   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      add_directed();
      add_random(100);
      drain();
      settings_run++;
      // writes to unused register slots must leave the grid alone
      write_csr(CSR_SPARE, 11'h7FF);
      write_csr(CSR_SPARE_HI, 11'h001);
      add_random(40);
      drain();
      run_setting(11'd1, 11'd2, 60);
      run_setting(11'd1024, 11'd1024, 120);
      idle_enable = 1'b0;
      run_setting(11'd0, 11'd0, 80);
      idle_enable = 1'b1;
      run_setting(11'h7FF, 11'h7FF, 80);
      run_setting(11'd3, 11'd2, 60);
      run_setting(11'd7, 11'd5, 80);
      run_setting(11'd1025, 11'd1, 60);
      run_setting(11'($urandom_range(1, 1024)), 11'($urandom_range(2, 1024)), 120);
      run_setting(11'($urandom_range(1, 64)), 11'($urandom_range(2, 64)), 120);
      $display("covered %0d grid settings incl. clamped and extreme sizes", settings_run);
      $display("checked %0d vertex, %0d triangle and %0d bad-request beats",
               vertex_beats, triangle_beats, bad_beats);
      if (errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

### uv_sphere_vertex_index_generator_core.f
rtl/uvs_pkg.sv
rtl/uvs_divider.sv
rtl/uvs_cordic.sv
rtl/uvs_delay.sv
rtl/uv_sphere_vertex_index_generator_core.sv
rtl/uvs_checker.sv
dv/uv_sphere_vertex_index_generator_core_tb.sv
